// ===== src/hsbrgb_pkg.sv =====
// shared types, constants and widths for the hsb to rgb converter
package hsbrgb_pkg;

    localparam int HUE_W       = 9;
    localparam int PCT_W       = 7;
    localparam int LEVEL_W     = 8;
    localparam int REM_W       = 6;
    localparam int X_W         = 13;
    localparam int BP_W        = 20;
    localparam int PROD_W      = 28;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 40;
    localparam int WIDE_W      = PROD_W + RECIP_W;
    localparam int NUM_LANES   = 3;

    localparam int FULL_CIRCLE   = 360;
    localparam int SECTOR_SPAN   = 60;
    localparam int PERCENT_FULL  = 100;
    localparam int X_FULL        = SECTOR_SPAN * PERCENT_FULL;
    localparam int LEVEL_DIVISOR = X_FULL * PERCENT_FULL;
    localparam int RECIP_MULT    = 1832519;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    localparam int HSBRGB_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic             black;
        sector_t          sector;
        logic [REM_W-1:0] rem;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bri;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic advance;
        logic s1_valid;
    } back_status_t;

endpackage

// ===== src/hsb_to_rgb_converter.sv =====
// top level of the hsb to rgb converter
// Converts hue (degrees), saturation and brightness (percent) into 8-bit red,
// green and blue levels, one transaction per clock sustained while the output is
// not stalled. An accepted input waits in the input fifo and then passes
// through the four-stage arithmetic pipeline (candidate values, brightness
// product, reciprocal divide by 600000, correction into the output register).
// The fifo holds QUEUE_DEPTH transactions, so the input keeps accepting while
// the output is stalled until the fifo fills.
module hsb_to_rgb_converter
    import hsbrgb_pkg::*;
#(
    parameter int QUEUE_DEPTH = HSBRGB_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [HUE_W-1:0]   hue_degrees,
    input  logic [PCT_W-1:0]   saturation_pct,
    input  logic [PCT_W-1:0]   brightness_pct,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] red_level,
    output logic [LEVEL_W-1:0] green_level,
    output logic [LEVEL_W-1:0] blue_level
);

    queue_status_t q_status;
    back_status_t  b_status;
    logic          q_push;
    logic          q_pop;
    item_t         push_item;
    item_t         pop_item;

    hsbrgb_front u_front
    (
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .brightness_pct (brightness_pct),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .q_status       (q_status),
        .push           (q_push),
        .push_item      (push_item)
    );

    hsbrgb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    hsbrgb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (pop_item),
        .q_valid     (!q_status.empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .status      (b_status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_status.empty)
        else $error("accepted transaction not held in fifo");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !in_ready)
        else $error("input ready while fifo full");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> b_status.s1_valid)
        else $error("popped transaction lost before first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push && !q_status.full) |-> !q_status.empty)
        else $error("pop from empty fifo");

endmodule

// ===== src/hsbrgb_front.sv =====
// front end: accepts transactions, clamps inputs and finds the hue sector
module hsbrgb_front
    import hsbrgb_pkg::*;
(
    input  logic [HUE_W-1:0] hue_degrees,
    input  logic [PCT_W-1:0] saturation_pct,
    input  logic [PCT_W-1:0] brightness_pct,
    input  logic             in_valid,
    output logic             in_ready,
    input  queue_status_t    q_status,
    output logic             push,
    output item_t            push_item
);

    logic [HUE_W-1:0] hue_eff;
    logic [HUE_W-1:0] hue_base;

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        hue_eff = (hue_degrees == HUE_W'(FULL_CIRCLE)) ? '0 : hue_degrees;
        push_item.black = (hue_degrees > HUE_W'(FULL_CIRCLE));
        push_item.sat = (saturation_pct > PCT_W'(PERCENT_FULL)) ?
                        PCT_W'(PERCENT_FULL) : saturation_pct;
        push_item.bri = (brightness_pct > PCT_W'(PERCENT_FULL)) ?
                        PCT_W'(PERCENT_FULL) : brightness_pct;
        priority if (hue_eff < HUE_W'(SECTOR_SPAN))
        begin
            push_item.sector = SECTOR_0;
            hue_base         = '0;
        end
        else if (hue_eff < HUE_W'(2 * SECTOR_SPAN))
        begin
            push_item.sector = SECTOR_1;
            hue_base         = HUE_W'(SECTOR_SPAN);
        end
        else if (hue_eff < HUE_W'(3 * SECTOR_SPAN))
        begin
            push_item.sector = SECTOR_2;
            hue_base         = HUE_W'(2 * SECTOR_SPAN);
        end
        else if (hue_eff < HUE_W'(4 * SECTOR_SPAN))
        begin
            push_item.sector = SECTOR_3;
            hue_base         = HUE_W'(3 * SECTOR_SPAN);
        end
        else if (hue_eff < HUE_W'(5 * SECTOR_SPAN))
        begin
            push_item.sector = SECTOR_4;
            hue_base         = HUE_W'(4 * SECTOR_SPAN);
        end
        else
        begin
            push_item.sector = SECTOR_5;
            hue_base         = HUE_W'(5 * SECTOR_SPAN);
        end
        push_item.rem = REM_W'(hue_eff - hue_base);
    end

endmodule

// ===== src/hsbrgb_queue.sv =====
// small fifo of classified transactions between front and back
module hsbrgb_queue
    import hsbrgb_pkg::*;
#(
    parameter int DEPTH = HSBRGB_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         pop_item,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/hsbrgb_back.sv =====
// back end: four-stage pipeline computing the three channel levels
module hsbrgb_back
    import hsbrgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              q_item,
    input  logic               q_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] red_level,
    output logic [LEVEL_W-1:0] green_level,
    output logic [LEVEL_W-1:0] blue_level,
    output back_status_t       status
);

    logic advance;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;

    logic [X_W-1:0]     x_next     [NUM_LANES];
    logic [X_W-1:0]     x_reg      [NUM_LANES];
    logic [PCT_W-1:0]   bri_reg;
    logic [PROD_W-1:0]  prod_next  [NUM_LANES];
    logic [PROD_W-1:0]  prod2_reg  [NUM_LANES];
    logic [PROD_W-1:0]  prod3_reg  [NUM_LANES];
    logic [LEVEL_W-1:0] qa_next    [NUM_LANES];
    logic [LEVEL_W-1:0] qa_reg     [NUM_LANES];
    logic [LEVEL_W-1:0] level_next [NUM_LANES];
    logic [LEVEL_W-1:0] level_reg  [NUM_LANES];

    logic [X_W-1:0]   sat_rem;
    logic [X_W-1:0]   sat_comp;
    logic [X_W-1:0]   xb;
    logic [X_W-1:0]   xp;
    logic [X_W-1:0]   xq;
    logic [X_W-1:0]   xt;
    logic [REM_W-1:0] rem_comp;
    logic [PCT_W-1:0] sat_inv;

    assign advance        = !s4_valid_reg || out_ready;
    assign pop            = advance && q_valid;
    assign out_valid      = s4_valid_reg;
    assign status.advance  = advance;
    assign status.s1_valid = s1_valid_reg;
    assign red_level      = level_reg[LANE_RED];
    assign green_level    = level_reg[LANE_GREEN];
    assign blue_level     = level_reg[LANE_BLUE];

    // stage 1: candidate values in units of 1/6000 and sector select
    always_comb
    begin
        rem_comp = REM_W'(SECTOR_SPAN) - q_item.rem;
        sat_inv  = PCT_W'(PERCENT_FULL) - q_item.sat;
        sat_rem  = X_W'(q_item.sat) * X_W'(q_item.rem);
        sat_comp = X_W'(q_item.sat) * X_W'(rem_comp);
        xb       = X_W'(X_FULL);
        xp       = X_W'(sat_inv) * X_W'(SECTOR_SPAN);
        xq       = xb - sat_rem;
        xt       = xb - sat_comp;
        unique case (q_item.sector)
            SECTOR_0:
            begin
                x_next[LANE_RED] = xb; x_next[LANE_GREEN] = xt; x_next[LANE_BLUE] = xp;
            end
            SECTOR_1:
            begin
                x_next[LANE_RED] = xq; x_next[LANE_GREEN] = xb; x_next[LANE_BLUE] = xp;
            end
            SECTOR_2:
            begin
                x_next[LANE_RED] = xp; x_next[LANE_GREEN] = xb; x_next[LANE_BLUE] = xt;
            end
            SECTOR_3:
            begin
                x_next[LANE_RED] = xp; x_next[LANE_GREEN] = xq; x_next[LANE_BLUE] = xb;
            end
            SECTOR_4:
            begin
                x_next[LANE_RED] = xt; x_next[LANE_GREEN] = xp; x_next[LANE_BLUE] = xb;
            end
            default:
            begin
                x_next[LANE_RED] = xb; x_next[LANE_GREEN] = xp; x_next[LANE_BLUE] = xq;
            end
        endcase
        if (q_item.black)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                x_next[i] = '0;
            end
        end
    end

    // stage 2: 255 * bright * x, stage 3: reciprocal estimate, stage 4: correction
    always_comb
    begin
        logic [BP_W-1:0]   bp;
        logic [WIDE_W-1:0] wide;
        logic [PROD_W-1:0] diff;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            bp            = BP_W'(bri_reg) * BP_W'(x_reg[i]);
            prod_next[i]  = {bp, 8'b0} - PROD_W'(bp);
            wide          = WIDE_W'(prod2_reg[i]) * WIDE_W'(RECIP_MULT);
            qa_next[i]    = LEVEL_W'(wide >> RECIP_SHIFT);
            diff          = prod3_reg[i] - PROD_W'(qa_reg[i]) * PROD_W'(LEVEL_DIVISOR);
            level_next[i] = (diff >= PROD_W'(LEVEL_DIVISOR)) ? qa_reg[i] + 1'b1 : qa_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bri_reg <= q_item.bri;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                x_reg[i]     <= x_next[i];
                prod2_reg[i] <= prod_next[i];
                prod3_reg[i] <= prod2_reg[i];
                qa_reg[i]    <= qa_next[i];
                level_reg[i] <= level_next[i];
            end
        end
    end

endmodule

// ===== tb/sv/hsbrgb_color_check.sv =====
`timescale 1ns / 100ps
// checker for the hsb to rgb converter: predicts each color and compares results in order
module hsbrgb_color_check
    import hsbrgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [HUE_W-1:0]   hue_degrees,
    input  logic [PCT_W-1:0]   saturation_pct,
    input  logic [PCT_W-1:0]   brightness_pct,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [LEVEL_W-1:0] red_level,
    input  logic [LEVEL_W-1:0] green_level,
    input  logic [LEVEL_W-1:0] blue_level,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 checked_count
);

    localparam int unsigned LEVEL_MAX = 255;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_t;

    rgb_t expected_rgb[$];
    rgb_t oldest_rgb;

    function automatic logic [LEVEL_W-1:0] scale_level(input int unsigned bri,
                                                       input int unsigned x);
        return LEVEL_W'((LEVEL_MAX * bri * x) / LEVEL_DIVISOR);
    endfunction

    function automatic rgb_t hsb_to_rgb(input logic [HUE_W-1:0] hue_in,
                                        input logic [PCT_W-1:0] sat_in,
                                        input logic [PCT_W-1:0] bri_in);
        int unsigned        hue;
        int unsigned        sat;
        int unsigned        bri;
        int unsigned        rem;
        logic [LEVEL_W-1:0] vb;
        logic [LEVEL_W-1:0] vp;
        logic [LEVEL_W-1:0] vq;
        logic [LEVEL_W-1:0] vt;
        sector_t            sector;
        rgb_t               color;
        hue   = 32'(hue_in);
        sat   = 32'(sat_in);
        bri   = 32'(bri_in);
        color = '0;
        if (sat > PERCENT_FULL)
            sat = PERCENT_FULL;
        if (bri > PERCENT_FULL)
            bri = PERCENT_FULL;
        if (hue == FULL_CIRCLE)
            hue = 0;
        if (hue < FULL_CIRCLE)
        begin
            sector = sector_t'(hue / SECTOR_SPAN);
            rem    = hue % SECTOR_SPAN;
            vb     = scale_level(bri, X_FULL);
            vp     = scale_level(bri, SECTOR_SPAN * (PERCENT_FULL - sat));
            vq     = scale_level(bri, X_FULL - sat * rem);
            vt     = scale_level(bri, X_FULL - sat * (SECTOR_SPAN - rem));
            unique case (sector)
                SECTOR_0: color = '{vb, vt, vp};
                SECTOR_1: color = '{vq, vb, vp};
                SECTOR_2: color = '{vp, vb, vt};
                SECTOR_3: color = '{vp, vq, vb};
                SECTOR_4: color = '{vt, vp, vb};
                default:  color = '{vb, vp, vq};
            endcase
        end
        return color;
    endfunction

    task automatic compare_level(input string field, input logic [LEVEL_W-1:0] want,
                                 input logic [LEVEL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_rgb.push_back(hsb_to_rgb(hue_degrees, saturation_pct, brightness_pct));
            if (out_valid && out_ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    $error("unexpected transaction: red %0d green %0d blue %0d",
                           red_level, green_level, blue_level);
                    mismatch_count++;
                end
                else
                begin
                    oldest_rgb = expected_rgb.pop_front();
                    compare_level("red_level", oldest_rgb.red, red_level);
                    compare_level("green_level", oldest_rgb.green, green_level);
                    compare_level("blue_level", oldest_rgb.blue, blue_level);
                    checked_count++;
                end
            end
            pending_count = expected_rgb.size();
        end
    end

endmodule

// ===== tb/sv/hsb_to_rgb_converter_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the hsb to rgb converter: clock, reset, stimulus, flow control and verdict
module hsb_to_rgb_converter_tb;
    import hsbrgb_pkg::*;

    localparam int RANDOM_ITEMS    = 1800;
    localparam int HOLD_OFF_AT     = 600;
    localparam int STEADY_FIRST    = 1100;
    localparam int STEADY_LAST     = 1400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int IDLE_PCT        = 33;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [HUE_W-1:0]   hue_degrees;
    logic [PCT_W-1:0]   saturation_pct;
    logic [PCT_W-1:0]   brightness_pct;
    logic               out_valid;
    logic               out_ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int sent_count;
    int black_count;
    int clamp_count;
    int quiet_cycles;
    bit steady_flow;
    bit hold_off_req;

    hsb_to_rgb_converter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .brightness_pct (brightness_pct),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level)
    );

    hsbrgb_color_check color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hue_degrees    (hue_degrees),
        .saturation_pct (saturation_pct),
        .brightness_pct (brightness_pct),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_hsb(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] bri);
        hue_degrees    <= hue;
        saturation_pct <= sat;
        brightness_pct <= bri;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        if (hue > HUE_W'(FULL_CIRCLE))
            black_count++;
        if (sat > PCT_W'(PERCENT_FULL) || bri > PCT_W'(PERCENT_FULL))
            clamp_count++;
        if (!steady_flow && !hold_off_req)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
                out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        hue_degrees    <= '0;
        saturation_pct <= '0;
        brightness_pct <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector boundaries, mostly at full saturation and brightness
        send_hsb(9'd0,   7'd100, 7'd100);
        send_hsb(9'd59,  7'd100, 7'd100);
        send_hsb(9'd60,  7'd100, 7'd100);
        send_hsb(9'd119, 7'd100, 7'd100);
        send_hsb(9'd120, 7'd100, 7'd100);
        send_hsb(9'd179, 7'd100, 7'd100);
        send_hsb(9'd180, 7'd50,  7'd100);
        send_hsb(9'd239, 7'd100, 7'd100);
        send_hsb(9'd240, 7'd100, 7'd100);
        send_hsb(9'd299, 7'd100, 7'd50);
        send_hsb(9'd300, 7'd100, 7'd100);
        send_hsb(9'd359, 7'd100, 7'd100);
        // full turn wraps, beyond it goes black
        send_hsb(9'd360, 7'd100, 7'd100);
        send_hsb(9'd361, 7'd100, 7'd100);
        send_hsb(9'd511, 7'd127, 7'd127);
        // saturation and brightness clamping and zeros
        send_hsb(9'd30,  7'd0,   7'd100);
        send_hsb(9'd30,  7'd101, 7'd100);
        send_hsb(9'd30,  7'd127, 7'd127);
        send_hsb(9'd90,  7'd100, 7'd101);
        send_hsb(9'd200, 7'd50,  7'd0);
        send_hsb(9'd0,   7'd0,   7'd0);
        send_hsb(9'd270, 7'd127, 7'd1);
        send_hsb(9'd45,  7'd1,   7'd127);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            steady_flow = (i >= STEADY_FIRST && i < STEADY_LAST);
            if ($urandom_range(99) < 70)
                send_hsb(HUE_W'($urandom_range(FULL_CIRCLE)),
                         PCT_W'($urandom_range(PERCENT_FULL)),
                         PCT_W'($urandom_range(PERCENT_FULL)));
            else
                send_hsb(HUE_W'($urandom_range((1 << HUE_W) - 1)),
                         PCT_W'($urandom_range((1 << PCT_W) - 1)),
                         PCT_W'($urandom_range((1 << PCT_W) - 1)));
        end
        steady_flow = 1'b0;
        in_valid <= 1'b0;

        while (checked_count < sent_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d colors checked, %0d past a full turn, %0d with clamped percent",
                 checked_count, black_count, clamp_count);
        $display("all six sectors, random stalls both sides and one %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
